FILE: design/quaternion_to_euler_zyx_core_assert.svh
// Assertion macros for the quaternion to Euler angle core.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef QUATERNION_TO_EULER_ZYX_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ZYX_CORE_ASSERT_SVH
// same-cycle implication
`define QE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qe assertion failed");
// implication with a fixed delay
`define QE_ASSERT_DLY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("qe latency assertion failed");
`endif

FILE: design/qe_pkg.sv
// Shared constants, types and the CORDIC angle table for the Euler core.
// No dependencies.
`timescale 1ns / 1ps
package qe_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int CS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int PW = 34;          // atan2 operand width
	localparam int RW = 34;          // radicand width (even)
	localparam int ISQ = RW / 2;     // square root stages
	localparam int QW = ISQ;         // root width
	localparam int CW = 37;          // CORDIC datapath width
	localparam int AW = 34;          // angle accumulator, 2^31 = pi
	localparam int OW = AW - 16;     // rounded angle width
	localparam int QUARTER_TURN = 16384;

	typedef struct packed {
		logic signed [PW-1:0] s_roll;
		logic signed [PW-1:0] c_roll;
		logic signed [PW-1:0] s_yaw;
		logic signed [PW-1:0] c_yaw;
		logic [RW-1:0]        ra;
		logic [RW-1:0]        rb;
	} prod_t;

	function automatic logic signed [AW-1:0] cordic_angle(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = AW'(536870912);
			1: r = AW'(316933406);
			2: r = AW'(167458907);
			3: r = AW'(85004756);
			4: r = AW'(42667331);
			5: r = AW'(21354465);
			6: r = AW'(10679838);
			7: r = AW'(5340245);
			8: r = AW'(2670163);
			9: r = AW'(1335087);
			10: r = AW'(667544);
			11: r = AW'(333772);
			12: r = AW'(166886);
			13: r = AW'(83443);
			14: r = AW'(41722);
			15: r = AW'(20861);
			16: r = AW'(10430);
			17: r = AW'(5215);
			18: r = AW'(2608);
			19: r = AW'(1304);
			20: r = AW'(652);
			21: r = AW'(326);
			22: r = AW'(163);
			23: r = AW'(81);
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

FILE: design/qe_prod.sv
// Product and sum stages: quaternion products, atan2 operands, radicands.
// Depends on qe_pkg.
`timescale 1ns / 1ps
module qe_prod (
	input  logic                clk,
	input  logic signed [15:0]  quat_w,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	output qe_pkg::prod_t       prod_s2
);
	import qe_pkg::*;

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, xz_s1;
	logic signed [35:0] s_r, c_r, s_y, c_y, t, ra, rb;
	prod_t nxt;

	always_ff @(posedge clk) begin
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		wz_s1 <= quat_w * quat_z;
		xy_s1 <= quat_x * quat_y;
		zz_s1 <= quat_z * quat_z;
		wy_s1 <= quat_w * quat_y;
		xz_s1 <= quat_x * quat_z;
	end

	always_comb begin
		s_r = 36'sd2 * (36'(wx_s1) + 36'(yz_s1));
		c_r = 36'sd1073741824 - 36'sd2 * (36'(xx_s1) + 36'(yy_s1));
		s_y = 36'sd2 * (36'(wz_s1) + 36'(xy_s1));
		c_y = 36'sd1073741824 - 36'sd2 * (36'(yy_s1) + 36'(zz_s1));
		t   = 36'(wy_s1) - 36'(xz_s1);
		ra  = 36'sd1073741824 + 36'sd2 * t;
		rb  = 36'sd1073741824 - 36'sd2 * t;
		nxt.s_roll = s_r[PW-1:0];
		nxt.c_roll = c_r[PW-1:0];
		nxt.s_yaw  = s_y[PW-1:0];
		nxt.c_yaw  = c_y[PW-1:0];
		// negative radicand saturates to zero
		nxt.ra = ra[35] ? '0 : ra[RW-1:0];
		nxt.rb = rb[35] ? '0 : rb[RW-1:0];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= nxt;
	end
endmodule

FILE: design/qe_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on qe_pkg.
`timescale 1ns / 1ps
module qe_isqrt (
	input  logic                  clk,
	input  logic [qe_pkg::RW-1:0] rad,
	output logic [qe_pkg::QW-1:0] root
);
	import qe_pkg::*;

	logic [RW-1:0] v_s [0:ISQ];
	logic [RW-1:0] r_s [0:ISQ];

	assign v_s[0] = rad;
	assign r_s[0] = '0;

	for (genvar k = 0; k < ISQ; k++) begin : g_st
		localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
		logic [RW-1:0] tr;
		assign tr = r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (v_s[k] >= tr) begin
				v_s[k+1] <= v_s[k] - tr;
				r_s[k+1] <= (r_s[k] >> 1) + BIT;
			end else begin
				v_s[k+1] <= v_s[k];
				r_s[k+1] <= r_s[k] >> 1;
			end
		end
	end

	assign root = r_s[ISQ][QW-1:0];
endmodule

FILE: design/qe_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) as a rounded binary angle.
// Depends on qe_pkg.
`timescale 1ns / 1ps
module qe_cordic (
	input  logic                        clk,
	input  logic signed [qe_pkg::CW-1:0] yin,
	input  logic signed [qe_pkg::CW-1:0] xin,
	output logic signed [qe_pkg::OW-1:0] angle_s
);
	import qe_pkg::*;

	logic signed [CW-1:0] x_s [0:CS];
	logic signed [CW-1:0] y_s [0:CS];
	logic signed [AW-1:0] a_s [0:CS];
	logic                 z_s [0:CS];
	logic signed [AW-1:0] rnd;

	// quadrant fold into the right half plane
	always_ff @(posedge clk) begin
		z_s[0] <= (xin == '0) && (yin == '0);
		if (xin < 0) begin
			if (yin >= 0) begin
				x_s[0] <= yin;
				y_s[0] <= -xin;
				a_s[0] <= AW'(QUARTER_TURN) <<< 16;
			end else begin
				x_s[0] <= -yin;
				y_s[0] <= xin;
				a_s[0] <= -(AW'(QUARTER_TURN) <<< 16);
			end
		end else begin
			x_s[0] <= xin;
			y_s[0] <= yin;
			a_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_rot
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			z_s[i+1] <= z_s[i];
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				a_s[i+1] <= a_s[i] + cordic_angle(i);
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				a_s[i+1] <= a_s[i] - cordic_angle(i);
			end
		end
	end

	assign rnd = (a_s[CS] + AW'(32768)) >>> 16;

	always_ff @(posedge clk) begin
		angle_s <= z_s[CS] ? '0 : rnd[OW-1:0];
	end
endmodule

FILE: design/quaternion_to_euler_zyx_core.sv
// Quaternion to Euler angle (Z-Y-X) core, fully pipelined.
// One item may start in every cycle: busy is always low, so an input
// transfer happens at each rising edge where start is high.
// Inputs quat_w/x/y/z are signed Q1.15; outputs roll/pitch/yaw are
// signed binary angles, 32768 = pi (roll and yaw wrap, pitch is clamped
// to +-16384).
// Pipeline: 2 product/sum stages, 17 square-root stages, fold + 16
// CORDIC rotation stages + round, and the output register. The CORDIC
// rotation stage count follows CORDIC_STEPS in qe_pkg: min(CORDIC_STEPS, 24).
// Throughput: one item per clock, set by the one-stage-per-step CORDIC
// and square-root pipelines.
// done is high for exactly one cycle per item with the result on the
// angle ports; the receiver takes it at the edge ending that cycle and
// cannot stall the block.
// Reset clears the valid line only; items in flight are dropped.
`timescale 1ns / 1ps
`include "quaternion_to_euler_zyx_core_assert.svh"
module quaternion_to_euler_zyx_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               done,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle
);
	import qe_pkg::*;

	localparam int LAT = 2 + ISQ + CS + 3;

	logic [LAT-1:0] vld_q;
	prod_t prod_s2;
	logic [QW-1:0] sqa, sqb;

	// roll/yaw operands wait while the radicand roots settle
	logic signed [PW-1:0] sr_s [0:ISQ];
	logic signed [PW-1:0] cr_s [0:ISQ];
	logic signed [PW-1:0] sy_s [0:ISQ];
	logic signed [PW-1:0] cy_s [0:ISQ];

	logic signed [OW-1:0] roll_a, pitch_a, yaw_a;
	logic signed [OW+1:0] pitch_w;
	logic signed [15:0]   pitch_sat;

	assign busy = 1'b0;

	// valid bit travels with each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end
	assign done = vld_q[LAT-1];

	qe_prod u_prod (
		.clk(clk), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
		.quat_z(quat_z), .prod_s2(prod_s2)
	);

	qe_isqrt u_sqa (.clk(clk), .rad(prod_s2.ra), .root(sqa));
	qe_isqrt u_sqb (.clk(clk), .rad(prod_s2.rb), .root(sqb));

	assign sr_s[0] = prod_s2.s_roll;
	assign cr_s[0] = prod_s2.c_roll;
	assign sy_s[0] = prod_s2.s_yaw;
	assign cy_s[0] = prod_s2.c_yaw;

	for (genvar k = 0; k < ISQ; k++) begin : g_dly
		always_ff @(posedge clk) begin
			sr_s[k+1] <= sr_s[k];
			cr_s[k+1] <= cr_s[k];
			sy_s[k+1] <= sy_s[k];
			cy_s[k+1] <= cy_s[k];
		end
	end

	qe_cordic u_roll (
		.clk(clk), .yin(CW'(sr_s[ISQ])), .xin(CW'(cr_s[ISQ])), .angle_s(roll_a)
	);
	qe_cordic u_pitch (
		.clk(clk), .yin(CW'(signed'({1'b0, sqa}))), .xin(CW'(signed'({1'b0, sqb}))),
		.angle_s(pitch_a)
	);
	qe_cordic u_yaw (
		.clk(clk), .yin(CW'(sy_s[ISQ])), .xin(CW'(cy_s[ISQ])), .angle_s(yaw_a)
	);

	// pitch = 2*atan2 - pi/2, clamped to a quarter turn
	always_comb begin
		pitch_w = (OW+2)'(pitch_a) * (OW+2)'(2) - (OW+2)'(QUARTER_TURN);
		if (pitch_w > (OW+2)'(QUARTER_TURN)) begin
			pitch_sat = 16'(QUARTER_TURN);
		end else if (pitch_w < -(OW+2)'(QUARTER_TURN)) begin
			pitch_sat = -16'(QUARTER_TURN);
		end else begin
			pitch_sat = pitch_w[15:0];
		end
	end

	always_ff @(posedge clk) begin
		roll_angle  <= roll_a[15:0];
		pitch_angle <= pitch_sat;
		yaw_angle   <= yaw_a[15:0];
	end

	`QE_ASSERT_DLY(a_latency, start, 38, done)
	`QE_ASSERT_DLY(a_no_phantom, !start, 38, !done)
	`QE_ASSERT_IMPL(a_pitch_range, done,
		(pitch_angle <= 16'sd16384) && (pitch_angle >= -16'sd16384))
endmodule
